/* hdl/pngsw_pkg.sv */
`default_nettype none
package pngsw_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [14:0] MAX_WIDTH = 15'd21844;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // positions in the per-item byte script
  localparam int POS_W = 7;
  localparam logic [POS_W-1:0] POS_HDR = 7'd0;   // signature, IHDR, IDAT head, zlib head
  localparam logic [POS_W-1:0] POS_ROW = 7'd43;  // stored block header and filter byte
  localparam logic [POS_W-1:0] POS_PIX = 7'd49;  // the pixel byte itself
  localparam logic [POS_W-1:0] POS_END = 7'd69;  // last IEND crc byte

  localparam logic [31:0] CRC_NIB [16] = '{
    32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
    32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
    32'hedb88320, 32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
    32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
  };

  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_WIDTH,
    SRC_HEIGHT,
    SRC_CRC,
    SRC_IDATLEN,
    SRC_BFINAL,
    SRC_BLEN,
    SRC_NLEN,
    SRC_PIXEL,
    SRC_ADLER
  } src_t;

  typedef struct packed {
    src_t        src;
    logic        crc_init;
    logic        crc_en;
    logic        adler_en;
    logic [1:0]  bsel;
    logic [7:0]  cval;
  } pos_info_t;

  // one classified input item
  typedef struct packed {
    logic [7:0]  pixel;
    logic [14:0] width;
    logic [14:0] height;
    logic        img_start;
    logic        row_start;
    logic        last_row;
    logic        img_end;
  } item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    c = (c >> 4) ^ CRC_NIB[c[3:0]];
    c = (c >> 4) ^ CRC_NIB[c[3:0]];
    return c;
  endfunction

  function automatic pos_info_t mk(input src_t src, input logic init, input logic crc,
                                   input logic adl, input logic [1:0] bsel,
                                   input logic [7:0] cval);
    pos_info_t pi;
    pi.src      = src;
    pi.crc_init = init;
    pi.crc_en   = crc;
    pi.adler_en = adl;
    pi.bsel     = bsel;
    pi.cval     = cval;
    return pi;
  endfunction

  function automatic pos_info_t pos_info(input logic [POS_W-1:0] k);
    pos_info_t pi;
    pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
    case (k)
      7'd0:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h89);
      7'd1:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h50);
      7'd2:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h4e);
      7'd3:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h47);
      7'd4:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h0d);
      7'd5:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h0a);
      7'd6:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h1a);
      7'd7:  pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h0a);
      7'd8, 7'd9, 7'd10:
             pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
      7'd11: pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h0d);
      7'd12: pi = mk(SRC_CONST, 1'b1, 1'b1, 1'b0, 2'd0, 8'h49);
      7'd13: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h48);
      7'd14: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h44);
      7'd15: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h52);
      7'd16: pi = mk(SRC_WIDTH, 1'b0, 1'b1, 1'b0, 2'd3, 8'h00);
      7'd17: pi = mk(SRC_WIDTH, 1'b0, 1'b1, 1'b0, 2'd2, 8'h00);
      7'd18: pi = mk(SRC_WIDTH, 1'b0, 1'b1, 1'b0, 2'd1, 8'h00);
      7'd19: pi = mk(SRC_WIDTH, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00);
      7'd20: pi = mk(SRC_HEIGHT, 1'b0, 1'b1, 1'b0, 2'd3, 8'h00);
      7'd21: pi = mk(SRC_HEIGHT, 1'b0, 1'b1, 1'b0, 2'd2, 8'h00);
      7'd22: pi = mk(SRC_HEIGHT, 1'b0, 1'b1, 1'b0, 2'd1, 8'h00);
      7'd23: pi = mk(SRC_HEIGHT, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00);
      7'd24: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h08);
      7'd25: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h02);
      7'd26, 7'd27, 7'd28:
             pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00);
      7'd29: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd3, 8'h00);
      7'd30: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd2, 8'h00);
      7'd31: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd1, 8'h00);
      7'd32: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
      7'd33: pi = mk(SRC_IDATLEN, 1'b0, 1'b0, 1'b0, 2'd3, 8'h00);
      7'd34: pi = mk(SRC_IDATLEN, 1'b0, 1'b0, 1'b0, 2'd2, 8'h00);
      7'd35: pi = mk(SRC_IDATLEN, 1'b0, 1'b0, 1'b0, 2'd1, 8'h00);
      7'd36: pi = mk(SRC_IDATLEN, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
      7'd37: pi = mk(SRC_CONST, 1'b1, 1'b1, 1'b0, 2'd0, 8'h49);
      7'd38: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h44);
      7'd39: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h41);
      7'd40: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h54);
      7'd41: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h78);
      7'd42: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h01);
      7'd43: pi = mk(SRC_BFINAL, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00);
      7'd44: pi = mk(SRC_BLEN, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00);
      7'd45: pi = mk(SRC_BLEN, 1'b0, 1'b1, 1'b0, 2'd1, 8'h00);
      7'd46: pi = mk(SRC_NLEN, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00);
      7'd47: pi = mk(SRC_NLEN, 1'b0, 1'b1, 1'b0, 2'd1, 8'h00);
      7'd48: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00);
      7'd49: pi = mk(SRC_PIXEL, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00);
      7'd50: pi = mk(SRC_ADLER, 1'b0, 1'b1, 1'b0, 2'd3, 8'h00);
      7'd51: pi = mk(SRC_ADLER, 1'b0, 1'b1, 1'b0, 2'd2, 8'h00);
      7'd52: pi = mk(SRC_ADLER, 1'b0, 1'b1, 1'b0, 2'd1, 8'h00);
      7'd53: pi = mk(SRC_ADLER, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00);
      7'd54: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd3, 8'h00);
      7'd55: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd2, 8'h00);
      7'd56: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd1, 8'h00);
      7'd57: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
      7'd58, 7'd59, 7'd60, 7'd61:
             pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
      7'd62: pi = mk(SRC_CONST, 1'b1, 1'b1, 1'b0, 2'd0, 8'h49);
      7'd63: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h45);
      7'd64: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h4e);
      7'd65: pi = mk(SRC_CONST, 1'b0, 1'b1, 1'b0, 2'd0, 8'h44);
      7'd66: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd3, 8'h00);
      7'd67: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd2, 8'h00);
      7'd68: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd1, 8'h00);
      7'd69: pi = mk(SRC_CRC, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
      default: pi = mk(SRC_CONST, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00);
    endcase
    return pi;
  endfunction

endpackage
`default_nettype wire

/* hdl/pngsw_front.sv */
`default_nettype none
module pngsw_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic [7:0]          in_tdata,
  input  wire logic [14:0]         cfg_width,
  input  wire logic [14:0]         cfg_height,
  input  wire logic                q_full,
  output logic                     in_tready,
  output logic                     push,
  output pngsw_pkg::item_t         push_item
);

  logic [15:0] byte_in_row_r, byte_in_row_nxt;
  logic [14:0] row_index_r, row_index_nxt;
  logic [14:0] w_eff, h_eff;
  logic [15:0] three_w;
  logic [15:0] bir_inc;
  logic        row_start, last_row, end_row;

  always_comb begin
    if (cfg_width == 15'd0) begin
      w_eff = 15'd1;
    end else if (cfg_width > pngsw_pkg::MAX_WIDTH) begin
      w_eff = pngsw_pkg::MAX_WIDTH;
    end else begin
      w_eff = cfg_width;
    end
    h_eff     = (cfg_height == 15'd0) ? 15'd1 : cfg_height;
    three_w   = {1'b0, w_eff} + {w_eff, 1'b0};
    bir_inc   = byte_in_row_r + 16'd1;
    row_start = (byte_in_row_r == 16'd0);
    last_row  = (row_index_r >= (h_eff - 15'd1));
    // a row closes once the count reaches or passes three bytes per pixel
    end_row   = (bir_inc >= three_w);
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_item.pixel     = in_tdata;
    push_item.width     = w_eff;
    push_item.height    = h_eff;
    push_item.row_start = row_start;
    push_item.img_start = row_start && (row_index_r == 15'd0);
    push_item.last_row  = last_row;
    push_item.img_end   = end_row && last_row;

    byte_in_row_nxt = byte_in_row_r;
    row_index_nxt   = row_index_r;
    if (push) begin
      if (end_row) begin
        byte_in_row_nxt = 16'd0;
        row_index_nxt   = last_row ? 15'd0 : row_index_r + 15'd1;
      end else begin
        byte_in_row_nxt = bir_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r <= 16'd0;
      row_index_r   <= 15'd0;
    end else begin
      byte_in_row_r <= byte_in_row_nxt;
      row_index_r   <= row_index_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/pngsw_queue.sv */
`default_nettype none
module pngsw_queue #(
  parameter int DEPTH = pngsw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pngsw_pkg::item_t  push_item,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output pngsw_pkg::item_t       head_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pngsw_pkg::item_t entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/pngsw_back.sv */
`default_nettype none
module pngsw_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire pngsw_pkg::item_t  head_item,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  localparam int PW = pngsw_pkg::POS_W;

  logic [PW-1:0]        k_r, k_cur, k_start;
  logic                 started_r;
  logic [31:0]          crc_r, crc_nxt, crc_base;
  logic [15:0]          adler_lo_r, adler_lo_nxt, adler_hi_r, adler_hi_nxt;
  logic [16:0]          lo_sum, hi_sum, lo_red;
  logic [31:0]          idat_len_r;
  logic [15:0]          blen;
  logic [16:0]          blen5;
  logic [31:0]          word;
  logic [7:0]           byte_val;
  logic                 advance, emit, last;
  pngsw_pkg::pos_info_t pi;

  logic                 out_valid_r;
  logic [7:0]           out_data_r;
  logic                 out_last_r, out_user_r;

  assign blen  = {1'b0, head_item.width} + {head_item.width, 1'b0} + 16'd1;
  assign blen5 = {1'b0, blen} + 17'd5;

  // idat length follows the head item; it is first read 33 bytes into the image header
  always_ff @(posedge clk) begin
    idat_len_r <= ({17'd0, head_item.height} * {15'd0, blen5}) + 32'd6;
  end

  always_comb begin
    if (head_item.img_start) begin
      k_start = pngsw_pkg::POS_HDR;
    end else if (head_item.row_start) begin
      k_start = pngsw_pkg::POS_ROW;
    end else begin
      k_start = pngsw_pkg::POS_PIX;
    end
    k_cur   = started_r ? k_r : k_start;
    pi      = pngsw_pkg::pos_info(k_cur);
    advance = !out_valid_r || out_tready;
    emit    = head_valid && advance;
    last    = (k_cur == pngsw_pkg::POS_END) ||
              ((k_cur == pngsw_pkg::POS_PIX) && !head_item.img_end);
    pop     = emit && last;

    case (pi.src)
      pngsw_pkg::SRC_CONST:   word = {24'd0, pi.cval};
      pngsw_pkg::SRC_WIDTH:   word = {17'd0, head_item.width};
      pngsw_pkg::SRC_HEIGHT:  word = {17'd0, head_item.height};
      pngsw_pkg::SRC_CRC:     word = ~crc_r;
      pngsw_pkg::SRC_IDATLEN: word = idat_len_r;
      pngsw_pkg::SRC_BFINAL:  word = {31'd0, head_item.last_row};
      pngsw_pkg::SRC_BLEN:    word = {16'd0, blen};
      pngsw_pkg::SRC_NLEN:    word = {16'd0, ~blen};
      pngsw_pkg::SRC_PIXEL:   word = {24'd0, head_item.pixel};
      pngsw_pkg::SRC_ADLER:   word = {adler_hi_r, adler_lo_r};
      default:                word = 32'd0;
    endcase
    byte_val = word[{pi.bsel, 3'b000} +: 8];

    crc_base = pi.crc_init ? 32'hffffffff : crc_r;
    crc_nxt  = crc_r;
    if (emit && pi.crc_en) begin
      crc_nxt = pngsw_pkg::crc_byte(crc_base, byte_val);
    end

    // both sums stay below twice the modulus, so one conditional subtract each
    lo_sum = {1'b0, adler_lo_r} + {9'd0, byte_val};
    lo_red = (lo_sum >= pngsw_pkg::ADLER_MOD) ? lo_sum - pngsw_pkg::ADLER_MOD : lo_sum;
    hi_sum = {1'b0, adler_hi_r} + lo_red;
    adler_lo_nxt = adler_lo_r;
    adler_hi_nxt = adler_hi_r;
    if (emit && (k_cur == pngsw_pkg::POS_HDR)) begin
      adler_lo_nxt = 16'd1;
      adler_hi_nxt = 16'd0;
    end else if (emit && pi.adler_en) begin
      adler_lo_nxt = lo_red[15:0];
      adler_hi_nxt = (hi_sum >= pngsw_pkg::ADLER_MOD) ?
                     16'(hi_sum - pngsw_pkg::ADLER_MOD) : hi_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      k_r         <= '0;
      crc_r       <= 32'hffffffff;
      adler_lo_r  <= 16'd1;
      adler_hi_r  <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      adler_lo_r <= adler_lo_nxt;
      adler_hi_r <= adler_hi_nxt;
      if (emit) begin
        started_r <= !last;
        k_r       <= k_cur + 1'b1;
      end
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= byte_val;
      out_last_r <= last;
      out_user_r <= (k_cur == pngsw_pkg::POS_END);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_started_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> head_valid)
    else $error("sequencer mid-item with empty queue");

  a_pos_in_script: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (k_r <= pngsw_pkg::POS_END))
    else $error("script position out of range");

  a_adler_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (adler_lo_r < 16'd65521) && (adler_hi_r < 16'd65521))
    else $error("adler sum not reduced");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r) |-> out_last_r)
    else $error("file end byte without tlast");

  a_pixel_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (k_cur == pngsw_pkg::POS_PIX) && !head_item.img_end) |=> !started_r)
    else $error("item not closed after pixel byte");

endmodule
`default_nettype wire

/* hdl/png_stored_rgb_stream_writer.sv */
// PNG writer for 8-bit RGB images with stored (uncompressed) deflate data. Pixel bytes
// enter in row order, R, G, B per pixel; the output stream is the complete PNG file, one
// byte per transfer. tlast marks the last byte caused by each input byte and tuser marks
// the final byte of the file. A mid-row pixel byte gives one byte out, back to back. The
// first byte of an image gives 50 bytes (signature, IHDR, IDAT head, zlib head, block
// header, filter byte, pixel), the first byte of any other row 7 and the last byte of the
// image 21 (Adler-32, IDAT crc, IEND); the sequencer emits one byte per cycle while the
// queue holds an item and out_tready allows. A 4-entry queue (QUEUE_DEPTH) between the
// input classifier and the sequencer lets input keep flowing while a header burst drains.
// Width (0x0) and height (0x4) are written through APB by the user only while idle; the
// block does not enforce it. Zero acts as one and widths above 21844 saturate.
`default_nettype none
module png_stored_rgb_stream_writer #(
  parameter int QUEUE_DEPTH = pngsw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] pixel_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] out_byte
  output logic             out_tlast,
  output logic             out_tuser,   // [0] file_done
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [14:0]      width_r, height_r;
  logic             q_full, push, pop, head_valid;
  pngsw_pkg::item_t push_item, head_item;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {17'd0, height_r} : {17'd0, width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 15'd1;
      height_r <= 15'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2]) begin
        height_r <= cfg_pwdata[14:0];
      end else begin
        width_r <= cfg_pwdata[14:0];
      end
    end
  end

  pngsw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .q_full     (q_full),
    .in_tready  (in_tready),
    .push       (push),
    .push_item  (push_item)
  );

  pngsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pngsw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
